@@ rtl/pfa_pkg.sv @@
`default_nettype none

package pfa_pkg;

  localparam int unsigned PcWidth = 4;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_TOTAL_MEMORY = 2'd0;
  localparam logic [1:0] CFG_FRAME_SIZE   = 2'd1;

  // Result status codes.
  localparam logic [2:0] STATUS_GRANTED     = 3'd0;
  localparam logic [2:0] STATUS_OVER_TOTAL  = 3'd1;
  localparam logic [2:0] STATUS_OVER_REMAIN = 3'd2;
  localparam logic [2:0] STATUS_SHORT       = 3'd3;
  localparam logic [2:0] STATUS_RELEASED    = 3'd4;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_LOAD,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_NEED,
    UOP_GRANT_INIT,
    UOP_GRANT_STEP,
    UOP_COMMIT,
    UOP_SET_TOTAL,
    UOP_SET_REMAIN,
    UOP_SET_SHORT,
    UOP_REL_INIT,
    UOP_REL_COUNT,
    UOP_EMIT
  } uop_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_IS_REL,
    COND_OVER_TOTAL,
    COND_OVER_REMAIN,
    COND_DIV_MORE,
    COND_NEED_SHORT,
    COND_NEED_ZERO,
    COND_GRANT_MORE,
    COND_BITS_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e               uop;
    cond_e              cond;
    logic [PcWidth-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    uop_e uop;
    logic accept;
  } pfa_ctrl_t;

  typedef struct packed {
    logic is_rel;
    logic over_total;
    logic over_remain;
    logic div_more;
    logic need_short;
    logic need_zero;
    logic grant_more;
    logic bits_more;
    logic out_busy;
  } pfa_flags_t;

  localparam logic [PcWidth-1:0] PC_FETCH  = 4'd0;
  localparam logic [PcWidth-1:0] PC_DIV    = 4'd5;
  localparam logic [PcWidth-1:0] PC_GRANT  = 4'd8;
  localparam logic [PcWidth-1:0] PC_COMMIT = 4'd9;
  localparam logic [PcWidth-1:0] PC_TOTAL  = 4'd10;
  localparam logic [PcWidth-1:0] PC_REMAIN = 4'd11;
  localparam logic [PcWidth-1:0] PC_SHORT  = 4'd12;
  localparam logic [PcWidth-1:0] PC_REL    = 4'd13;
  localparam logic [PcWidth-1:0] PC_COUNT  = 4'd14;
  localparam logic [PcWidth-1:0] PC_EMIT   = 4'd15;

  // Microprogram. A taken condition jumps to the target, otherwise the
  // step counter advances; the last step wraps back to the fetch step.
  function automatic ctrl_word_t ucode_rom(logic [PcWidth-1:0] pc);
    ctrl_word_t cw;
    unique case (pc)
      4'd0:  cw = '{UOP_LOAD,       COND_NO_INPUT,    PC_FETCH};
      4'd1:  cw = '{UOP_NOP,        COND_IS_REL,      PC_REL};
      4'd2:  cw = '{UOP_NOP,        COND_OVER_TOTAL,  PC_TOTAL};
      4'd3:  cw = '{UOP_NOP,        COND_OVER_REMAIN, PC_REMAIN};
      4'd4:  cw = '{UOP_DIV_INIT,   COND_NEVER,       PC_FETCH};
      4'd5:  cw = '{UOP_DIV_STEP,   COND_DIV_MORE,    PC_DIV};
      4'd6:  cw = '{UOP_NEED,       COND_NEED_SHORT,  PC_SHORT};
      4'd7:  cw = '{UOP_GRANT_INIT, COND_NEED_ZERO,   PC_COMMIT};
      4'd8:  cw = '{UOP_GRANT_STEP, COND_GRANT_MORE,  PC_GRANT};
      4'd9:  cw = '{UOP_COMMIT,     COND_ALWAYS,      PC_EMIT};
      4'd10: cw = '{UOP_SET_TOTAL,  COND_ALWAYS,      PC_EMIT};
      4'd11: cw = '{UOP_SET_REMAIN, COND_ALWAYS,      PC_EMIT};
      4'd12: cw = '{UOP_SET_SHORT,  COND_ALWAYS,      PC_EMIT};
      4'd13: cw = '{UOP_REL_INIT,   COND_NEVER,       PC_FETCH};
      4'd14: cw = '{UOP_REL_COUNT,  COND_BITS_MORE,   PC_COUNT};
      4'd15: cw = '{UOP_EMIT,       COND_OUT_BUSY,    PC_EMIT};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pfa_datapath.sv @@
`default_nettype none

module pfa_datapath import pfa_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire pfa_ctrl_t   ctrl_i,
  output pfa_flags_t       flags_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        operation_i,
  input  wire logic [15:0] request_size_i,
  input  wire logic [15:0] release_mask_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [15:0]      granted_mask_o,
  output logic [4:0]       frame_count_o,
  output logic [11:0]      fragmentation_o,
  output logic [15:0]      memory_left_o,
  output logic [4:0]       frames_left_o
);

  localparam int unsigned CntWidth = $clog2(NUM_FRAMES + 1);

  // Architectural state.
  logic [15:0]           total_q;
  logic [12:0]           frame_size_q;
  logic [NUM_FRAMES-1:0] free_map_q;
  logic [15:0]           remaining_q;
  logic [CntWidth-1:0]   free_count_q;
  logic                  out_valid_q;

  // Working registers of one transaction.
  logic                  op_q;
  logic [15:0]           req_q;
  logic [15:0]           rel_q;
  logic [15:0]           dq_q;
  logic [12:0]           r_q;
  logic [3:0]            div_cnt_q;
  logic [16:0]           need_q;
  logic [CntWidth-1:0]   gcnt_q;
  logic [NUM_FRAMES-1:0] work_q;
  logic [NUM_FRAMES-1:0] grant_q;
  logic [4:0]            count_q;
  logic [11:0]           frag_q;
  logic [2:0]            status_q;

  logic [12:0]           fs_eff;
  logic [13:0]           r_shift;
  logic                  q_bit;
  logic [13:0]           r_sub;
  logic [16:0]           need_calc;
  logic [NUM_FRAMES-1:0] low_bit;
  logic [NUM_FRAMES-1:0] work_dec;
  logic [NUM_FRAMES+15:0] rel_ext;
  logic [NUM_FRAMES-1:0] map_rel;
  logic [16:0]           rel_sum;
  logic [12:0]           frag_diff;
  logic                  emit_load;
  logic [NUM_FRAMES+15:0] grant_ext;
  logic [CntWidth+4:0]   free_ext;

  assign fs_eff    = (frame_size_q == 13'd0) ? 13'd1 : frame_size_q;
  assign r_shift   = {r_q, dq_q[15]};
  assign q_bit     = (r_shift >= {1'b0, fs_eff});
  assign r_sub     = r_shift - {1'b0, fs_eff};
  assign need_calc = {1'b0, dq_q} + {16'd0, (r_q != 13'd0)};
  assign low_bit   = work_q & (~work_q + {{(NUM_FRAMES-1){1'b0}}, 1'b1});
  assign work_dec  = work_q & (work_q - {{(NUM_FRAMES-1){1'b0}}, 1'b1});
  assign rel_ext   = {{NUM_FRAMES{1'b0}}, rel_q};
  assign map_rel   = free_map_q | rel_ext[NUM_FRAMES-1:0];
  assign rel_sum   = {1'b0, remaining_q} + {1'b0, req_q};
  assign frag_diff = fs_eff - r_q;
  assign emit_load = (ctrl_i.uop == UOP_EMIT) && !(out_valid_q && out_stall_i);
  assign grant_ext = {16'd0, grant_q};
  assign free_ext  = {5'd0, free_count_q};

  assign flags_o.is_rel      = op_q;
  assign flags_o.over_total  = (req_q > total_q);
  assign flags_o.over_remain = (req_q > remaining_q);
  assign flags_o.div_more    = (div_cnt_q != 4'd15);
  assign flags_o.need_short  = (need_calc > {{(17-CntWidth){1'b0}}, free_count_q});
  assign flags_o.need_zero   = (need_q == 17'd0);
  assign flags_o.grant_more  = (gcnt_q != {{(CntWidth-1){1'b0}}, 1'b1});
  assign flags_o.bits_more   = (work_dec != '0);
  assign flags_o.out_busy    = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= 16'd500;
      frame_size_q <= 13'd50;
      free_map_q   <= '1;
      remaining_q  <= 16'd500;
      free_count_q <= CntWidth'(NUM_FRAMES);
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_TOTAL_MEMORY)) begin
        total_q     <= cfg_wdata_i;
        remaining_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_index_i == CFG_FRAME_SIZE)) begin
        frame_size_q <= cfg_wdata_i[12:0];
      end
      unique case (ctrl_i.uop)
        UOP_COMMIT: begin
          free_map_q   <= work_q;
          free_count_q <= free_count_q - need_q[CntWidth-1:0];
          remaining_q  <= remaining_q - req_q;
        end
        UOP_REL_INIT: begin
          free_map_q   <= map_rel;
          free_count_q <= '0;
          remaining_q  <= (rel_sum > {1'b0, total_q}) ? total_q : rel_sum[15:0];
        end
        UOP_REL_COUNT: begin
          if (work_q != '0) begin
            free_count_q <= free_count_q + {{(CntWidth-1){1'b0}}, 1'b1};
          end
        end
        default: begin
        end
      endcase
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.uop)
      UOP_LOAD: begin
        if (ctrl_i.accept) begin
          op_q    <= operation_i;
          req_q   <= request_size_i;
          rel_q   <= release_mask_i;
          grant_q <= '0;
          count_q <= 5'd0;
          frag_q  <= 12'd0;
        end
      end
      UOP_DIV_INIT: begin
        dq_q      <= req_q;
        r_q       <= 13'd0;
        div_cnt_q <= 4'd0;
      end
      UOP_DIV_STEP: begin
        // Restoring division, one quotient bit per step.
        r_q       <= q_bit ? r_sub[12:0] : r_shift[12:0];
        dq_q      <= {dq_q[14:0], q_bit};
        div_cnt_q <= div_cnt_q + 4'd1;
      end
      UOP_NEED: begin
        need_q <= need_calc;
      end
      UOP_GRANT_INIT: begin
        work_q <= free_map_q;
        gcnt_q <= need_q[CntWidth-1:0];
      end
      UOP_GRANT_STEP: begin
        // Take the lowest free frame.
        grant_q <= grant_q | low_bit;
        work_q  <= work_q & ~low_bit;
        gcnt_q  <= gcnt_q - {{(CntWidth-1){1'b0}}, 1'b1};
      end
      UOP_COMMIT: begin
        status_q <= STATUS_GRANTED;
        count_q  <= need_q[4:0];
        if (r_q != 13'd0) begin
          frag_q <= (frag_diff > 13'd4095) ? 12'hFFF : frag_diff[11:0];
        end
      end
      UOP_SET_TOTAL:  status_q <= STATUS_OVER_TOTAL;
      UOP_SET_REMAIN: status_q <= STATUS_OVER_REMAIN;
      UOP_SET_SHORT:  status_q <= STATUS_SHORT;
      UOP_REL_INIT: begin
        status_q <= STATUS_RELEASED;
        work_q   <= map_rel;
      end
      UOP_REL_COUNT: begin
        // Clear the lowest set bit each step to count the free frames.
        work_q <= work_dec;
      end
      default: begin
      end
    endcase
    if (emit_load) begin
      status_o        <= status_q;
      granted_mask_o  <= grant_ext[15:0];
      frame_count_o   <= count_q;
      fragmentation_o <= frag_q;
      memory_left_o   <= remaining_q;
      frames_left_o   <= free_ext[4:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/paging_frame_allocator.sv @@
`default_nettype none

// Paged frame allocator. Each input transaction is either an allocation of
// request_size_i memory units or a release of the frames in release_mask_i,
// and yields exactly one result transaction. A small microprogram steps a
// shared datapath. An allocation is checked against the total and the
// remaining memory, rounded up to frames by the restoring divider and then
// granted frame by frame, lowest free frame first. A release frees the frames
// and then counts the free frames again. The next transaction is taken in
// the cycle after the result is loaded. The output register holds a finished
// result, so a new transaction is taken while the previous result waits; the
// block only waits at its last step when the previous result has not been
// taken yet. Configuration must be written only while the block is idle; the
// block itself does not enforce this. Writing the total memory also refills
// the remaining memory.
module paging_frame_allocator import pfa_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [15:0] request_size_i,
  input  wire logic [15:0] release_mask_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [15:0]      granted_mask_o,
  output logic [4:0]       frame_count_o,
  output logic [11:0]      fragmentation_o,
  output logic [15:0]      memory_left_o,
  output logic [4:0]       frames_left_o
);

  logic [PcWidth-1:0] pc_q, pc_d;
  ctrl_word_t         cw;
  pfa_ctrl_t          ctrl;
  pfa_flags_t         flags;
  logic               take;

  assign cw          = ucode_rom(pc_q);
  assign in_stall_o  = (pc_q != PC_FETCH);
  assign ctrl.uop    = cw.uop;
  assign ctrl.accept = in_valid_i && (pc_q == PC_FETCH);

  always_comb begin
    unique case (cw.cond)
      COND_NEVER:       take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_INPUT:    take = !in_valid_i;
      COND_IS_REL:      take = flags.is_rel;
      COND_OVER_TOTAL:  take = flags.over_total;
      COND_OVER_REMAIN: take = flags.over_remain;
      COND_DIV_MORE:    take = flags.div_more;
      COND_NEED_SHORT:  take = flags.need_short;
      COND_NEED_ZERO:   take = flags.need_zero;
      COND_GRANT_MORE:  take = flags.grant_more;
      COND_BITS_MORE:   take = flags.bits_more;
      COND_OUT_BUSY:    take = flags.out_busy;
      default:          take = 1'b0;
    endcase
    pc_d = take ? cw.target : pc_q + {{(PcWidth-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  pfa_datapath #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .flags_o        (flags),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .request_size_i (request_size_i),
    .release_mask_i (release_mask_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .granted_mask_o (granted_mask_o),
    .frame_count_o  (frame_count_o),
    .fragmentation_o(fragmentation_o),
    .memory_left_o  (memory_left_o),
    .frames_left_o  (frames_left_o)
  );

endmodule

`default_nettype wire

@@ tb/tb_paging_frame_allocator.sv @@
`timescale 1ns / 100ps

module tb_paging_frame_allocator;
  import pfa_pkg::*;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [1:0] CFG_UNUSED = 2'd2;

  localparam int unsigned NUM_FRAMES  = 16;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned PHASE_ITEMS = 80;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted_mask;
    logic [4:0]  frame_count;
    logic [11:0] fragmentation;
    logic [15:0] memory_left;
    logic [4:0]  frames_left;
  } frame_result_t;

  typedef struct packed {
    logic [15:0] mask;
    logic [15:0] size;
  } live_alloc_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_index_i    = '0;
  logic [15:0] cfg_wdata_i    = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        operation_i    = 1'b0;
  logic [15:0] request_size_i = '0;
  logic [15:0] release_mask_i = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] granted_mask_o;
  logic [4:0]  frame_count_o;
  logic [11:0] fragmentation_o;
  logic [15:0] memory_left_o;
  logic [4:0]  frames_left_o;

  paging_frame_allocator #(.NUM_FRAMES(NUM_FRAMES)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .request_size_i (request_size_i),
    .release_mask_i (release_mask_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .granted_mask_o (granted_mask_o),
    .frame_count_o  (frame_count_o),
    .fragmentation_o(fragmentation_o),
    .memory_left_o  (memory_left_o),
    .frames_left_o  (frames_left_o)
  );

  always #1 clk_i = ~clk_i;

  // Allocator state as the block should hold it.
  logic [15:0] model_total      = 16'd500;
  logic [12:0] model_frame_size = 13'd50;
  logic [15:0] model_free_map   = 16'hFFFF;
  logic [15:0] model_remaining  = 16'd500;
  logic [4:0]  model_free_count = 5'd16;

  frame_result_t pending_results [$];
  live_alloc_t   live_allocs [$];
  int unsigned   error_count = 0;
  int unsigned   burst_left  = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic frame_result_t predict_frame_op(input logic op,
                                                     input logic [15:0] req,
                                                     input logic [15:0] rel);
    frame_result_t res;
    int unsigned   fs;
    int unsigned   rem;
    int unsigned   need;
    int unsigned   sum;
    int unsigned   frag;
    int unsigned   taken;
    logic [15:0]   avail;
    res = '0;
    if (op == OP_RELEASE) begin
      sum = model_remaining + req;
      model_free_map = model_free_map | rel;
      model_free_count = 5'($countones(model_free_map));
      model_remaining = (sum > model_total) ? model_total : 16'(sum);
      res.status = STATUS_RELEASED;
    end else if (req > model_total) begin
      res.status = STATUS_OVER_TOTAL;
    end else if (req > model_remaining) begin
      res.status = STATUS_OVER_REMAIN;
    end else begin
      // A frame size of zero behaves as a size of one.
      fs = (model_frame_size == 0) ? 1 : model_frame_size;
      rem = req % fs;
      need = req / fs + ((rem != 0) ? 1 : 0);
      if (need > model_free_count) begin
        res.status = STATUS_SHORT;
      end else begin
        avail = model_free_map;
        taken = 0;
        for (int k = 0; k < NUM_FRAMES; k++) begin
          if (taken < need && avail[k]) begin
            res.granted_mask[k] = 1'b1;
            avail[k] = 1'b0;
            taken++;
          end
        end
        model_free_map = avail;
        model_free_count = model_free_count - 5'(need);
        model_remaining = model_remaining - req;
        res.frame_count = 5'(need);
        frag = (rem != 0) ? fs - rem : 0;
        res.fragmentation = (frag > 4095) ? 12'd4095 : 12'(frag);
        res.status = STATUS_GRANTED;
      end
    end
    res.memory_left = model_remaining;
    res.frames_left = model_free_count;
    return res;
  endfunction

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_item(input logic op, input logic [15:0] req,
                           input logic [15:0] rel, output frame_result_t res);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    request_size_i <= req;
    release_mask_i <= rel;
    do @(posedge clk_i); while (in_stall_o);
    res = predict_frame_op(op, req, rel);
    pending_results.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    drain_results();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TOTAL_MEMORY) begin
      model_total = data;
      model_remaining = data;
    end else if (idx == CFG_FRAME_SIZE) begin
      model_frame_size = data[12:0];
    end
  endtask

  task automatic test_limits();
    frame_result_t r;
    send_item(OP_ALLOC, 16'd0, 16'h0000, r);
    send_item(OP_ALLOC, 16'd501, 16'hFFFF, r);
    send_item(OP_ALLOC, 16'd500, 16'h0000, r);
    send_item(OP_ALLOC, 16'd1, 16'h0000, r);
    send_item(OP_RELEASE, 16'd500, 16'h03FF, r);
    send_item(OP_ALLOC, 16'd125, 16'h0000, r);
    send_item(OP_RELEASE, 16'hFFFF, 16'hFFFF, r);
  endtask

  task automatic test_frame_shortage();
    frame_result_t r;
    write_reg(CFG_TOTAL_MEMORY, 16'hFFFF);
    write_reg(CFG_FRAME_SIZE, 16'd1);
    send_item(OP_ALLOC, 16'd17, 16'h0000, r);
    send_item(OP_ALLOC, 16'd16, 16'h0000, r);
    send_item(OP_ALLOC, 16'd0, 16'h0000, r);
    send_item(OP_ALLOC, 16'd1, 16'h0000, r);
    send_item(OP_RELEASE, 16'd0, 16'hAAAA, r);
    send_item(OP_RELEASE, 16'hFFFF, 16'h5555, r);
  endtask

  task automatic test_frame_size_edges();
    frame_result_t r;
    write_reg(CFG_FRAME_SIZE, 16'd0);
    send_item(OP_ALLOC, 16'd3, 16'h0000, r);
    send_item(OP_RELEASE, 16'd3, 16'h0007, r);
    // Upper data bits fall outside the 13-bit register.
    write_reg(CFG_FRAME_SIZE, 16'hFFFF);
    send_item(OP_ALLOC, 16'd1, 16'h0000, r);
    send_item(OP_ALLOC, 16'hFFFF, 16'h0000, r);
    send_item(OP_RELEASE, 16'd1, 16'h0001, r);
    send_item(OP_ALLOC, 16'hFFFF, 16'h0000, r);
    write_reg(CFG_FRAME_SIZE, 16'd4096);
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_item(OP_RELEASE, 16'hFFFF, 16'hFFFF, r);
    send_item(OP_ALLOC, 16'hFFFF, 16'h0000, r);
    write_reg(CFG_TOTAL_MEMORY, 16'd1);
    send_item(OP_RELEASE, 16'd0, 16'hFFFF, r);
    send_item(OP_ALLOC, 16'd1, 16'h0000, r);
    send_item(OP_ALLOC, 16'd2, 16'h0000, r);
  endtask

  task automatic run_random_phase(input logic [15:0] total, input logic [15:0] fsize);
    frame_result_t r;
    live_alloc_t   entry;
    int unsigned   pick;
    int unsigned   idx;
    int unsigned   fs;
    int unsigned   k;
    int unsigned   sz;
    write_reg(CFG_TOTAL_MEMORY, total);
    write_reg(CFG_FRAME_SIZE, fsize);
    live_allocs.delete();
    send_item(OP_RELEASE, 16'd0, 16'hFFFF, r);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == PHASE_ITEMS / 2) drain_results();
      pick = $urandom_range(0, 99);
      fs = (model_frame_size == 0) ? 1 : model_frame_size;
      if (live_allocs.size() != 0 && (pick < 40 || (model_free_count == 0 && pick < 70))) begin
        idx = $urandom_range(0, live_allocs.size() - 1);
        entry = live_allocs[idx];
        live_allocs.delete(idx);
        send_item(OP_RELEASE, entry.size, entry.mask, r);
      end else if (pick < 85) begin
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 4);
        sz = k * fs;
        if (k != 0 && $urandom_range(0, 1) == 1) sz = sz - $urandom_range(0, fs - 1);
        if (sz > 65535) sz = 65535;
        send_item(OP_ALLOC, 16'(sz), 16'($urandom()), r);
        if (r.status == STATUS_GRANTED) begin
          entry.mask = r.granted_mask;
          entry.size = 16'(sz);
          live_allocs.push_back(entry);
        end
      end else begin
        send_item(1'($urandom()), 16'($urandom()), 16'($urandom()), r);
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(16'd500, 16'd50);
    run_random_phase(16'hFFFF, 16'd4096);
    run_random_phase(16'd1, 16'd1);
    run_random_phase(16'd2000, 16'd100);
    run_random_phase(16'hFFFF, 16'd1);
    run_random_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 4096)));
    run_random_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 4096)));
    run_random_phase(16'd4000, 16'($urandom_range(1, 300)));
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_limits();
    test_frame_shortage();
    test_frame_size_edges();
    test_random_traffic();
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS paging_frame_allocator");
    end else begin
      $display("FAIL paging_frame_allocator");
    end
    $finish;
  end

  // Receiver stall pattern: modes of random length, from none to heavy.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= 1'($urandom_range(0, 1));
      2: out_stall_i <= ($urandom_range(0, 7) != 0);
      default: out_stall_i <= stall_tick[2];
    endcase
  end

  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with none pending, status", status_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (granted_mask_o !== want.granted_mask)
          report_mismatch("granted_mask", granted_mask_o, want.granted_mask);
        if (frame_count_o !== want.frame_count)
          report_mismatch("frame_count", frame_count_o, want.frame_count);
        if (fragmentation_o !== want.fragmentation)
          report_mismatch("fragmentation", fragmentation_o, want.fragmentation);
        if (memory_left_o !== want.memory_left)
          report_mismatch("memory_left", memory_left_o, want.memory_left);
        if (frames_left_o !== want.frames_left)
          report_mismatch("frames_left", frames_left_o, want.frames_left);
      end
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL paging_frame_allocator");
      $finish;
    end
  end

endmodule
